/* rtl/pnrd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pnrd_pkg
// Types and constants for the packed note record decoder.
// ----------------------------------------------------------------------------
package pnrd_pkg;

	localparam logic [7:0] FLAG_BIT   = 8'h80;
	localparam logic [7:0] ABSENT     = 8'hFF;
	localparam logic [7:0] KEY_OFF    = 8'hFE;
	localparam logic [7:0] KEY_OFF_IN = 8'd97;
	localparam logic [7:0] EFFECT_LIM = 8'h10;

	localparam logic [1:0] RAW_INSTR  = 2'd0;
	localparam logic [1:0] RAW_VOLUME = 2'd1;
	localparam logic [1:0] RAW_EFFECT = 2'd2;
	localparam logic [1:0] RAW_PARAM  = 2'd3;

	typedef struct packed {
		logic [7:0] note;
		logic [7:0] instr;
		logic [7:0] volume;
		logic [7:0] effect;
		logic [7:0] param;
	} note_hold_t;

	typedef struct packed {
		logic [7:0] note;
		logic [7:0] instr;
		logic [7:0] volume;
		logic [3:0] effect;
		logic [7:0] param;
	} note_cmd_t;

	localparam note_hold_t HOLD_DEFAULT = '{
		note:   ABSENT,
		instr:  8'h00,
		volume: ABSENT,
		effect: ABSENT,
		param:  ABSENT
	};

	function automatic note_cmd_t map_record(input note_hold_t h);
		note_cmd_t c;
		c.instr  = h.instr;
		c.volume = h.volume;
		if (h.note == 8'h00 || h.note == ABSENT) begin
			c.note = ABSENT;
		end else if (h.note == KEY_OFF_IN) begin
			c.note = KEY_OFF;
		end else begin
			c.note = h.note - 8'd1;
		end
		if (h.effect < EFFECT_LIM) begin
			c.effect = h.effect[3:0];
			c.param  = (h.param == ABSENT) ? 8'h00 : h.param;
		end else begin
			c.effect = 4'h0;
			c.param  = 8'h00;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* rtl/packed_note_record_decoder_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// packed_note_record_decoder_core
// Decodes a packed pattern byte stream into five-field note commands.
// ----------------------------------------------------------------------------
// Takes one stream byte per beat, one beat per cycle unless stalled, and
// issues one note command beat for each completed record, in the cycle after
// the byte that completes it. A lead byte with bit 7 set is a flag byte
// naming which of note, instrument, volume, effect and argument follow;
// otherwise it is the note and four raw bytes follow. The decode state and
// field holds update per accepted byte; the result sits in an output register,
// so bytes flow every cycle while commands are taken, and stream_stall rises
// in every cycle in which a finished command is held by note_stall.
module packed_note_record_decoder_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       stream_valid,
	output logic            stream_stall,
	input  wire logic [7:0] stream_byte,
	output logic            note_valid,
	input  wire logic       note_stall,
	output logic [7:0]      note_code,
	output logic [7:0]      instrument_number,
	output logic [7:0]      volume_column,
	output logic [3:0]      effect_code,
	output logic [7:0]      effect_param
);
	import pnrd_pkg::*;

	logic       in_record_q, in_record_n;
	logic       packed_form_q, packed_form_n;
	logic [4:0] pending_q, pending_n;
	logic [1:0] raw_index_q, raw_index_n;
	note_hold_t hold_q, hold_n;
	logic       emit;
	logic       accept;
	note_cmd_t  cmd;
	note_cmd_t  cmd_q;
	logic       note_valid_q;

	assign stream_stall = note_valid_q && note_stall;
	assign accept       = stream_valid && !stream_stall;

	always_comb begin
		in_record_n   = in_record_q;
		packed_form_n = packed_form_q;
		pending_n     = pending_q;
		raw_index_n   = raw_index_q;
		hold_n        = hold_q;
		emit          = 1'b0;
		if (!in_record_q) begin
			hold_n      = HOLD_DEFAULT;
			raw_index_n = RAW_INSTR;
			if ((stream_byte & FLAG_BIT) != 8'h00) begin
				packed_form_n = 1'b1;
				pending_n     = stream_byte[4:0];
				if (stream_byte[4:0] == 5'd0) begin
					emit = 1'b1;
				end else begin
					in_record_n = 1'b1;
				end
			end else begin
				packed_form_n = 1'b0;
				pending_n     = 5'd0;
				hold_n.note   = stream_byte;
				in_record_n   = 1'b1;
			end
		end else if (packed_form_q) begin
			if (pending_q[0]) begin
				hold_n.note  = stream_byte;
				pending_n[0] = 1'b0;
			end else if (pending_q[1]) begin
				hold_n.instr = stream_byte;
				pending_n[1] = 1'b0;
			end else if (pending_q[2]) begin
				hold_n.volume = stream_byte;
				pending_n[2]  = 1'b0;
			end else if (pending_q[3]) begin
				hold_n.effect = stream_byte;
				pending_n[3]  = 1'b0;
			end else begin
				hold_n.param = stream_byte;
				pending_n    = 5'd0;
			end
			emit = (pending_n == 5'd0);
		end else begin
			case (raw_index_q)
				RAW_INSTR: begin
					hold_n.instr = stream_byte;
					raw_index_n  = RAW_VOLUME;
				end
				RAW_VOLUME: begin
					hold_n.volume = stream_byte;
					raw_index_n   = RAW_EFFECT;
				end
				RAW_EFFECT: begin
					hold_n.effect = stream_byte;
					raw_index_n   = RAW_PARAM;
				end
				default: begin
					hold_n.param = stream_byte;
					emit         = 1'b1;
				end
			endcase
		end
		if (emit) begin
			in_record_n = 1'b0;
			pending_n   = 5'd0;
			raw_index_n = RAW_INSTR;
		end
	end

	assign cmd = map_record(hold_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_record_q   <= 1'b0;
			packed_form_q <= 1'b0;
			pending_q     <= 5'd0;
			raw_index_q   <= RAW_INSTR;
			hold_q        <= HOLD_DEFAULT;
		end else if (accept) begin
			in_record_q   <= in_record_n;
			packed_form_q <= packed_form_n;
			pending_q     <= pending_n;
			raw_index_q   <= raw_index_n;
			hold_q        <= hold_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_valid_q <= 1'b0;
		end else if (accept && emit) begin
			note_valid_q <= 1'b1;
		end else if (!note_stall) begin
			note_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			cmd_q <= cmd;
		end
	end

	assign note_valid        = note_valid_q;
	assign note_code         = cmd_q.note;
	assign instrument_number = cmd_q.instr;
	assign volume_column     = cmd_q.volume;
	assign effect_code       = cmd_q.effect;
	assign effect_param      = cmd_q.param;

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		stream_stall |-> note_valid_q)
		else $error("stream stalled with no pending result");

	a_empty_flag_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_record_q && stream_byte[7] && stream_byte[4:0] == 5'd0)
		|=> (note_valid_q && !in_record_q && effect_code == 4'h0 && effect_param == 8'h00))
		else $error("empty flag byte did not emit a default record");

	a_raw_lead_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_record_q && !stream_byte[7])
		|=> (in_record_q && !packed_form_q && raw_index_q == RAW_INSTR))
		else $error("raw lead byte did not open a raw record");

	a_packed_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(in_record_q && packed_form_q) |-> (pending_q != 5'd0))
		else $error("open packed record with no pending fields");

endmodule
`default_nettype wire
